FILE: rtl/core/ets_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ets_pkg;

  localparam int unsigned PC_W    = 4;
  localparam int unsigned DAYS_W  = 16;
  localparam int unsigned YOFF_W  = 8;

  // year offsets are counted from 1970
  localparam logic [YOFF_W-1:0] YOFF_FAT_BASE = 8'd10;
  localparam logic [YOFF_W-1:0] YOFF_2100     = 8'd130;
  localparam logic [3:0]        MONTH_DEC     = 4'd11;

  // x / 60 == (x * RECIP_60) >> 37 and x / 24 == (x * RECIP_24) >> 36 for any 32-bit x
  localparam logic [31:0] RECIP_60 = 32'h8888_8889;
  localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;
  localparam int unsigned Q60_LSB  = 37;
  localparam int unsigned Q24_LSB  = 36;

  localparam logic [8:0] YEAR_DAYS = 9'd365;
  localparam logic [8:0] LEAP_DAYS = 9'd366;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_DIV60,
    OP_DIV24,
    OP_SEC,
    OP_MIN,
    OP_HOUR,
    OP_YEAR,
    OP_MONTH,
    OP_EMIT,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IDLE,
    C_YEARMORE,
    C_MONMORE,
    C_OUTBUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic year_more;
    logic mon_more;
    logic out_busy;
  } stat_t;

  // control store: jump to target when cond holds, else fall through
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{OP_LOAD,  C_IDLE,     4'd0};
      4'd1:    w = '{OP_DIV60, C_ALWAYS,   4'd2};
      4'd2:    w = '{OP_SEC,   C_ALWAYS,   4'd3};
      4'd3:    w = '{OP_DIV60, C_ALWAYS,   4'd4};
      4'd4:    w = '{OP_MIN,   C_ALWAYS,   4'd5};
      4'd5:    w = '{OP_DIV24, C_ALWAYS,   4'd6};
      4'd6:    w = '{OP_HOUR,  C_ALWAYS,   4'd7};
      4'd7:    w = '{OP_YEAR,  C_YEARMORE, 4'd7};
      4'd8:    w = '{OP_MONTH, C_MONMORE,  4'd8};
      4'd9:    w = '{OP_EMIT,  C_OUTBUSY,  4'd9};
      default: w = '{OP_NOP,   C_ALWAYS,   4'd0};
    endcase
    return w;
  endfunction

  // valid for the years 1970..2199 only; 2100 is the sole century year there that is not a leap year
  function automatic logic is_leap(input logic [YOFF_W-1:0] yoff);
    return (yoff[1:0] == 2'd2) && (yoff != YOFF_2100);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon) inside
      4'd1:                     len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ets_useq.sv
`timescale 1ns / 1ps
`default_nettype none
module ets_useq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire ets_pkg::stat_t stat,
  output ets_pkg::ctrl_t     ctrl,
  output logic               idle
);
  import ets_pkg::*;

  logic [PC_W-1:0]  pc_r, pc_nxt;
  uword_t           uw;
  logic             take;

  always_comb begin
    uw = ucode(pc_r);
    case (uw.cond)
      C_ALWAYS:   take = 1'b1;
      C_IDLE:     take = !in_tvalid;
      C_YEARMORE: take = stat.year_more;
      C_MONMORE:  take = stat.mon_more;
      C_OUTBUSY:  take = stat.out_busy;
      default:    take = 1'b0;
    endcase
    pc_nxt = take ? uw.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.op = uw.op;
  assign idle    = (pc_r == '0);

endmodule
`default_nettype wire

FILE: rtl/core/ets_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module ets_dpath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ets_pkg::ctrl_t ctrl,
  output ets_pkg::stat_t     stat,
  input  wire logic [31:0]   in_word,
  input  wire logic          out_tready,
  output logic               out_tvalid,
  output logic [31:0]        out_tdata,
  output logic               out_tuser
);
  import ets_pkg::*;

  logic [31:0]        num_r, num_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [5:0]         sec_r, sec_nxt;
  logic [5:0]         min_r, min_nxt;
  logic [4:0]         hour_r, hour_nxt;
  logic [DAYS_W-1:0]  days_r, days_nxt;
  logic [YOFF_W-1:0]  yoff_r, yoff_nxt;
  logic [3:0]         mon_r, mon_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [31:0]        odata_r, odata_nxt;
  logic               orange_r, orange_nxt;

  logic [31:0]        recip;
  logic [31:0]        q60;
  logic [31:0]        q24;
  logic [31:0]        rem60;
  logic [31:0]        rem24;
  logic               leap;
  logic [8:0]         ylen;
  logic [4:0]         mlen;
  logic               in_fat;
  logic [6:0]         fat_year;
  logic               out_busy;

  // quotient from the registered reciprocal product, remainder by shift and subtract
  assign recip = (ctrl.op == OP_DIV24) ? RECIP_24 : RECIP_60;
  assign q60   = 32'(prod_r[63:Q60_LSB]);
  assign q24   = 32'(prod_r[63:Q24_LSB]);
  assign rem60 = num_r - ((q60 << 6) - (q60 << 2));
  assign rem24 = num_r - ((q24 << 5) - (q24 << 3));

  assign leap     = is_leap(yoff_r);
  assign ylen     = leap ? LEAP_DAYS : YEAR_DAYS;
  assign mlen     = month_len(mon_r, leap);
  assign in_fat   = (yoff_r >= YOFF_FAT_BASE);
  assign fat_year = 7'(yoff_r - YOFF_FAT_BASE);
  assign out_busy = ovalid_r && !out_tready;

  assign stat.year_more = (days_r >= DAYS_W'(ylen));
  assign stat.mon_more  = (mon_r != MONTH_DEC) && (days_r >= DAYS_W'(mlen));
  assign stat.out_busy  = out_busy;

  always_comb begin
    num_nxt    = num_r;
    prod_nxt   = prod_r;
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    hour_nxt   = hour_r;
    days_nxt   = days_r;
    yoff_nxt   = yoff_r;
    mon_nxt    = mon_r;
    odata_nxt  = odata_r;
    orange_nxt = orange_r;
    ovalid_nxt = ovalid_r && !out_tready;
    case (ctrl.op)
      OP_LOAD: begin
        num_nxt = in_word;
      end
      OP_DIV60, OP_DIV24: begin
        prod_nxt = 64'(num_r) * 64'(recip);
      end
      OP_SEC: begin
        sec_nxt = rem60[5:0];
        num_nxt = q60;
      end
      OP_MIN: begin
        min_nxt = rem60[5:0];
        num_nxt = q60;
      end
      OP_HOUR: begin
        hour_nxt = rem24[4:0];
        days_nxt = q24[DAYS_W-1:0];
        yoff_nxt = '0;
        mon_nxt  = '0;
      end
      OP_YEAR: begin
        if (stat.year_more) begin
          days_nxt = days_r - DAYS_W'(ylen);
          yoff_nxt = yoff_r + 1'b1;
        end
      end
      OP_MONTH: begin
        if (stat.mon_more) begin
          days_nxt = days_r - DAYS_W'(mlen);
          mon_nxt  = mon_r + 1'b1;
        end
      end
      OP_EMIT: begin
        if (!out_busy) begin
          ovalid_nxt = 1'b1;
          orange_nxt = in_fat;
          odata_nxt  = in_fat ? {fat_year, mon_r + 4'd1, days_r[4:0] + 5'd1,
                                 hour_r, min_r, sec_r[5:1]} : 32'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
    num_r    <= num_nxt;
    prod_r   <= prod_nxt;
    sec_r    <= sec_nxt;
    min_r    <= min_nxt;
    hour_r   <= hour_nxt;
    days_r   <= days_nxt;
    yoff_r   <= yoff_nxt;
    mon_r    <= mon_nxt;
    odata_r  <= odata_nxt;
    orange_r <= orange_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = orange_r;

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_EMIT && !out_busy) |=> out_tvalid)
    else $error("emitted word not presented");

  a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 32'd0))
    else $error("out of range word not cleared");

  a_month_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_MONTH) |-> (mon_r <= MONTH_DEC))
    else $error("month walk past december");

  a_day_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_EMIT) |-> (days_r < DAYS_W'(31)))
    else $error("day of month out of range");

endmodule
`default_nettype wire

FILE: rtl/core/epoch_seconds_to_fat_timestamp.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | tdata                      | tuser
// in_     | in  | [31:0] seconds_since_epoch | -
// out_    | out | [31:0] fat_datetime        | [0] in_range
//
// one word takes an accept step, 3 reciprocal multiplies each followed by a field split,
// a year walk that steps until the days left are fewer than that year holds, a month walk
// that steps until the days left fit the month or december is reached, then an emit step
// that waits while out_ tvalid is still held; in_tready is high only while the sequencer sits at its idle step
// the result register lets the next word start while out_ tvalid waits
// rst_n is synchronous, active low; it clears the step counter and out_tvalid
module epoch_seconds_to_fat_timestamp (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] seconds_since_epoch
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] fat_datetime
  output logic             out_tuser   // [0] in_range
);
  import ets_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  ets_useq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .ctrl      (ctrl),
    .idle      (in_tready)
  );

  ets_dpath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_word    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int NUM_DIR      = 24;
  localparam int NUM_RAND     = 630;
  localparam int MAX_GAP      = 12;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 800;
  localparam int PAUSE_AT     = 200;
  localparam int CALM_FIRST   = 400;
  localparam int CALM_LAST    = 479;
  localparam int DRAIN_CYCLES = 250;
  localparam int QUIET_LIMIT  = 6000;

  localparam logic [31:0] FAT_EPOCH_SECS = 32'd315532800;
  localparam int unsigned EPOCH_YEAR     = 1970;
  localparam int unsigned FAT_BASE_YEAR  = 1980;
  localparam int unsigned FAT_LAST_YEAR  = 2107;

  // day of year at some month edges, hits february end in leap years too
  localparam int unsigned MONTH_EDGE [6] = '{0, 31, 59, 60, 334, 365};

  typedef struct {
    logic [31:0] secs;
    logic [31:0] word;
    logic        in_range;
  } stamp_t;

  typedef struct {
    logic [31:0] secs;
    logic        fixed;     // expected value typed into the row
    logic [31:0] word;
    logic        in_range;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;

  stamp_t   stamps_due [$];
  dir_row_t dir_rows [NUM_DIR];

  int  n_words_sent;
  int  n_stamps_checked;
  int  n_pre1980;
  int  n_leap_days;
  int  n_mismatch;
  int  quiet_cycles;
  bit  calm;
  bit  held;

  epoch_seconds_to_fat_timestamp dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit leap_year(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // gregorian calendar split of a seconds count into the fat date-time word
  function automatic stamp_t fat_stamp(input logic [31:0] secs);
    stamp_t      r;
    int unsigned t;
    int unsigned sec;
    int unsigned mins;
    int unsigned hour;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    int unsigned ylen;
    int unsigned mlen;
    t    = secs;
    sec  = t % 60;
    t    = t / 60;
    mins = t % 60;
    t    = t / 60;
    hour = t % 24;
    days = t / 24;
    yr   = EPOCH_YEAR;
    mon  = 0;
    forever begin
      ylen = leap_year(yr) ? 366 : 365;
      if (days < ylen) break;
      days -= ylen;
      yr++;
    end
    while (mon < 11) begin
      case (mon)
        1:       mlen = leap_year(yr) ? 29 : 28;
        3, 5, 8, 10: mlen = 30;
        default: mlen = 31;
      endcase
      if (days < mlen) break;
      days -= mlen;
      mon++;
    end
    r.secs = secs;
    if (yr < FAT_BASE_YEAR || yr > FAT_LAST_YEAR) begin
      r.word     = '0;
      r.in_range = 1'b0;
    end else begin
      r.word = {7'(yr - FAT_BASE_YEAR), 4'(mon + 1), 5'(days + 1), 5'(hour), 6'(mins),
                5'(sec >> 1)};
      r.in_range = 1'b1;
    end
    return r;
  endfunction

  task automatic send_word(input logic [31:0] secs, input bit fixed, input logic [31:0] word,
                           input logic in_range);
    stamp_t e;
    int     gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = secs;
    do @(posedge clk); while (!in_tready);
    if (fixed) begin
      e.secs     = secs;
      e.word     = word;
      e.in_range = in_range;
    end else begin
      e = fat_stamp(secs);
    end
    stamps_due.push_back(e);
    n_words_sent++;
    @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int     stall;
    stamp_t e;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (n_stamps_checked == HOLD_AT && !held) begin
        held       = 1'b1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        stall = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (stall > 0) begin
          out_tready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (stamps_due.size() == 0) begin
        n_mismatch++;
        $display("%0t: unexpected word tdata=%h tuser=%b", $realtime, out_tdata, out_tuser);
      end else begin
        e = stamps_due.pop_front();
        n_stamps_checked++;
        if (!e.in_range) n_pre1980++;
        if (e.in_range && e.word[24:21] == 4'd2 && e.word[20:16] == 5'd29) n_leap_days++;
        if (out_tdata !== e.word) begin
          n_mismatch++;
          $display("%0t: secs=%0d fat_datetime expected %h actual %h", $realtime, e.secs,
                   e.word, out_tdata);
        end
        if (out_tuser !== e.in_range) begin
          n_mismatch++;
          $display("%0t: secs=%0d in_range expected %b actual %b", $realtime, e.secs,
                   e.in_range, out_tuser);
        end
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int          kind;
    int unsigned yoff;
    int unsigned d;
    longint      wide;
    logic [31:0] secs;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    calm         = 1'b0;
    held         = 1'b0;
    quiet_cycles = 0;

    dir_rows = '{
      '{32'd0,          1'b1, 32'h0000_0000, 1'b0},
      '{32'd59,         1'b1, 32'h0000_0000, 1'b0},
      '{32'd315532799,  1'b1, 32'h0000_0000, 1'b0},
      '{FAT_EPOCH_SECS, 1'b1, 32'h0021_0000, 1'b1},
      '{32'hFFFF_FFFF,  1'b1, 32'hFC47_3387, 1'b1},
      '{32'd315532859,  1'b0, 32'h0, 1'b0},
      '{32'd315619199,  1'b0, 32'h0, 1'b0},
      '{32'd347155199,  1'b0, 32'h0, 1'b0},
      '{32'd347155200,  1'b0, 32'h0, 1'b0},
      '{32'd951782399,  1'b0, 32'h0, 1'b0},
      '{32'd951782400,  1'b0, 32'h0, 1'b0},
      '{32'd951868800,  1'b0, 32'h0, 1'b0},
      '{32'd978307199,  1'b0, 32'h0, 1'b0},
      '{32'd978307200,  1'b0, 32'h0, 1'b0},
      '{32'd4102444799, 1'b0, 32'h0, 1'b0},
      '{32'd4102444800, 1'b0, 32'h0, 1'b0},
      '{32'd4107456000, 1'b0, 32'h0, 1'b0},
      '{32'd4107542399, 1'b0, 32'h0, 1'b0},
      '{32'd4107542400, 1'b0, 32'h0, 1'b0},
      '{32'h7FFF_FFFF,  1'b0, 32'h0, 1'b0},
      '{32'h8000_0000,  1'b0, 32'h0, 1'b0},
      '{32'h5555_5555,  1'b0, 32'h0, 1'b0},
      '{32'hAAAA_AAAA,  1'b0, 32'h0, 1'b0},
      '{32'hFFFF_FFFE,  1'b0, 32'h0, 1'b0}
    };

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].secs, dir_rows[i].fixed, dir_rows[i].word, dir_rows[i].in_range);

    for (int i = 0; i < NUM_RAND; i++) begin
      calm = (i >= CALM_FIRST && i <= CALM_LAST);
      if (i == PAUSE_AT) begin
        in_tvalid = 1'b0;
        while (stamps_due.size() != 0) @(negedge clk);
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: secs = $urandom;
        4:          secs = $urandom_range(0, 315532799);
        5, 6: begin
          // near midnight on a random day
          d    = $urandom_range(0, 49709);
          wide = longint'(d) * 86400 +
                 ($urandom_range(0, 1) ? $urandom_range(0, 3) : 86399 - $urandom_range(0, 3));
          secs = wide[31:0];
        end
        default: begin
          // around a month or year edge of a random year
          yoff = $urandom_range(0, 136);
          d    = 0;
          for (int k = 0; k < yoff; k++) d += leap_year(EPOCH_YEAR + k) ? 366 : 365;
          d   += MONTH_EDGE[$urandom_range(0, 5)];
          wide = longint'(d) * 86400 + longint'($urandom_range(0, 3)) - 2;
          if (wide < 0) wide = 0;
          if (wide > 64'hFFFF_FFFF) wide = 64'hFFFF_FFFF;
          secs = wide[31:0];
        end
      endcase
      send_word(secs, 1'b0, 32'h0, 1'b0);
    end
    in_tvalid = 1'b0;
    calm      = 1'b0;

    while (stamps_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d words, checked %0d stamps: %0d before 1980, %0d on february 29",
             n_words_sent, n_stamps_checked, n_pre1980, n_leap_days);
    $display("%0d mismatches, with random stalls, a long output hold-off and a drain pause",
             n_mismatch);
    if (n_mismatch == 0 && stamps_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
